@@ sv/rpi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rpi_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int EPS          = 7;
  localparam int U_DIR        = 21928;
  localparam int V_DIR        = 42159;

  localparam int CRD_W     = 32;
  localparam int PLN_W     = 18;
  localparam int OFS_W     = 32;
  localparam int CNT_W     = 5;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 33;
  localparam int PROD_W    = 2 * OP_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int Q_W       = 37;
  localparam int DVD_W     = Q_W + 16;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = 6;
  localparam int PSUM_W    = 52;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_A,
    REG_PLANE_B,
    REG_PLANE_C,
    REG_PLANE_D,
    REG_VERTEX_COUNT
  } cfg_reg_e;

  typedef enum logic [4:0] {
    M_NONE,
    M_A_DX, M_B_DY, M_C_DZ,
    M_A_OX, M_B_OY, M_C_OZ,
    M_DX_T, M_DY_T, M_DZ_T,
    M_DY_U, M_DX_V, M_DY_EX, M_DX_EY,
    M_EY_U, M_EX_V, M_FY_U, M_FX_V
  } mul_sel_e;

  typedef enum logic [2:0] {
    A_HOLD,
    A_LOAD,
    A_ADD,
    A_SUB,
    A_LOAD_D
  } acc_op_e;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_VWRITE,
    ACT_CAPTURE,
    ACT_DEN,
    ACT_NUM,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_TFIN,
    ACT_PX, ACT_PY, ACT_PZ,
    ACT_FIRST,
    ACT_CUR,
    ACT_WRAP,
    ACT_PREV,
    ACT_LSC,
    ACT_SR,
    ACT_S0,
    ACT_CROSS,
    ACT_OUT
  } act_e;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_DEN0, ST_DEN1, ST_DEN2, ST_DEN3, ST_DEN4,
    ST_NUM0, ST_NUM1, ST_NUM2, ST_NUM3, ST_NUM4,
    ST_DIV_INIT, ST_DIV, ST_TFIN,
    ST_P0, ST_P1, ST_P2, ST_P3,
    ST_RD0, ST_FIRST, ST_LOOP, ST_CUR,
    ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_E6, ST_E7, ST_E8, ST_E9, ST_E10,
    ST_NEXT, ST_DONE
  } state_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    act_e     act;
  } cmd_t;

  typedef struct packed {
    logic den_small;
    logic t_small;
  } status_t;

  function automatic logic signed [CRD_W-1:0] sat32(input logic signed [PSUM_W-1:0] x);
    logic signed [PSUM_W-1:0] hi;
    logic signed [PSUM_W-1:0] lo;
    hi = PSUM_W'(64'sd2147483647);
    lo = -PSUM_W'(64'sd2147483648);
    if (x > hi) begin
      return 32'h7FFF_FFFF;
    end else if (x < lo) begin
      return 32'h8000_0000;
    end
    return x[CRD_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/rpi_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rpi_ctrl #(
  parameter int MaxVertices = rpi_pkg::MAX_VERTICES,
  localparam int AW = $clog2(MaxVertices),
  localparam int CW = $clog2(MaxVertices + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             cmd_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire rpi_pkg::status_t status_i,
  input  wire logic [CW-1:0]    vcnt_i,
  output rpi_pkg::cmd_t         cmd_o,
  output logic [AW-1:0]         rd_addr_o
);

  rpi_pkg::state_e state_q, state_d;
  logic [rpi_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic last_q, last_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpi_pkg::ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != rpi_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign rd_addr_o   = idx_q[AW-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '{rpi_pkg::M_NONE, rpi_pkg::A_HOLD, rpi_pkg::ACT_NONE};
    case (state_q)
      rpi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i) begin
            cmd_o.act = rpi_pkg::ACT_CAPTURE;
            state_d   = rpi_pkg::ST_DEN0;
          end else begin
            cmd_o.act = rpi_pkg::ACT_VWRITE;
          end
        end
      end
      // plane normal dot direction
      rpi_pkg::ST_DEN0: begin
        cmd_o.mul_sel = rpi_pkg::M_A_DX;
        state_d       = rpi_pkg::ST_DEN1;
      end
      rpi_pkg::ST_DEN1: begin
        cmd_o.mul_sel = rpi_pkg::M_B_DY;
        cmd_o.acc_op  = rpi_pkg::A_LOAD;
        state_d       = rpi_pkg::ST_DEN2;
      end
      rpi_pkg::ST_DEN2: begin
        cmd_o.mul_sel = rpi_pkg::M_C_DZ;
        cmd_o.acc_op  = rpi_pkg::A_ADD;
        state_d       = rpi_pkg::ST_DEN3;
      end
      rpi_pkg::ST_DEN3: begin
        cmd_o.acc_op = rpi_pkg::A_ADD;
        state_d      = rpi_pkg::ST_DEN4;
      end
      rpi_pkg::ST_DEN4: begin
        cmd_o.act = rpi_pkg::ACT_DEN;
        state_d   = rpi_pkg::ST_NUM0;
      end
      rpi_pkg::ST_NUM0: begin
        if (status_i.den_small) begin
          state_d = rpi_pkg::ST_DONE;
        end else begin
          cmd_o.mul_sel = rpi_pkg::M_A_OX;
          cmd_o.acc_op  = rpi_pkg::A_LOAD_D;
          state_d       = rpi_pkg::ST_NUM1;
        end
      end
      rpi_pkg::ST_NUM1: begin
        cmd_o.mul_sel = rpi_pkg::M_B_OY;
        cmd_o.acc_op  = rpi_pkg::A_ADD;
        state_d       = rpi_pkg::ST_NUM2;
      end
      rpi_pkg::ST_NUM2: begin
        cmd_o.mul_sel = rpi_pkg::M_C_OZ;
        cmd_o.acc_op  = rpi_pkg::A_ADD;
        state_d       = rpi_pkg::ST_NUM3;
      end
      rpi_pkg::ST_NUM3: begin
        cmd_o.acc_op = rpi_pkg::A_ADD;
        state_d      = rpi_pkg::ST_NUM4;
      end
      rpi_pkg::ST_NUM4: begin
        cmd_o.act = rpi_pkg::ACT_NUM;
        state_d   = rpi_pkg::ST_DIV_INIT;
      end
      rpi_pkg::ST_DIV_INIT: begin
        cmd_o.act = rpi_pkg::ACT_DIV_INIT;
        cnt_d     = '0;
        state_d   = rpi_pkg::ST_DIV;
      end
      rpi_pkg::ST_DIV: begin
        cmd_o.act = rpi_pkg::ACT_DIV_STEP;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == rpi_pkg::DIV_CNT_W'(rpi_pkg::DIV_STEPS - 1)) begin
          state_d = rpi_pkg::ST_TFIN;
        end
      end
      rpi_pkg::ST_TFIN: begin
        cmd_o.act = rpi_pkg::ACT_TFIN;
        state_d   = rpi_pkg::ST_P0;
      end
      rpi_pkg::ST_P0: begin
        if (status_i.t_small) begin
          state_d = rpi_pkg::ST_DONE;
        end else begin
          cmd_o.mul_sel = rpi_pkg::M_DX_T;
          state_d       = rpi_pkg::ST_P1;
        end
      end
      rpi_pkg::ST_P1: begin
        cmd_o.mul_sel = rpi_pkg::M_DY_T;
        cmd_o.act     = rpi_pkg::ACT_PX;
        state_d       = rpi_pkg::ST_P2;
      end
      rpi_pkg::ST_P2: begin
        cmd_o.mul_sel = rpi_pkg::M_DZ_T;
        cmd_o.act     = rpi_pkg::ACT_PY;
        state_d       = rpi_pkg::ST_P3;
      end
      rpi_pkg::ST_P3: begin
        cmd_o.act = rpi_pkg::ACT_PZ;
        idx_d     = '0;
        state_d   = (vcnt_i == '0) ? rpi_pkg::ST_DONE : rpi_pkg::ST_RD0;
      end
      rpi_pkg::ST_RD0: begin
        state_d = rpi_pkg::ST_FIRST;
      end
      rpi_pkg::ST_FIRST: begin
        cmd_o.act = rpi_pkg::ACT_FIRST;
        idx_d     = CW'(1);
        state_d   = rpi_pkg::ST_LOOP;
      end
      // closing edge goes back to the first vertex
      rpi_pkg::ST_LOOP: begin
        if (idx_q < vcnt_i) begin
          last_d  = 1'b0;
          state_d = rpi_pkg::ST_CUR;
        end else begin
          cmd_o.act = rpi_pkg::ACT_WRAP;
          last_d    = 1'b1;
          state_d   = rpi_pkg::ST_E1;
        end
      end
      rpi_pkg::ST_CUR: begin
        cmd_o.act = rpi_pkg::ACT_CUR;
        state_d   = rpi_pkg::ST_E1;
      end
      rpi_pkg::ST_E1: begin
        cmd_o.mul_sel = rpi_pkg::M_DY_U;
        state_d       = rpi_pkg::ST_E2;
      end
      rpi_pkg::ST_E2: begin
        cmd_o.mul_sel = rpi_pkg::M_DX_V;
        cmd_o.acc_op  = rpi_pkg::A_LOAD;
        state_d       = rpi_pkg::ST_E3;
      end
      rpi_pkg::ST_E3: begin
        cmd_o.mul_sel = rpi_pkg::M_DY_EX;
        cmd_o.acc_op  = rpi_pkg::A_SUB;
        state_d       = rpi_pkg::ST_E4;
      end
      rpi_pkg::ST_E4: begin
        cmd_o.mul_sel = rpi_pkg::M_DX_EY;
        cmd_o.acc_op  = rpi_pkg::A_LOAD;
        cmd_o.act     = rpi_pkg::ACT_LSC;
        state_d       = rpi_pkg::ST_E5;
      end
      rpi_pkg::ST_E5: begin
        cmd_o.mul_sel = rpi_pkg::M_EY_U;
        cmd_o.acc_op  = rpi_pkg::A_SUB;
        state_d       = rpi_pkg::ST_E6;
      end
      rpi_pkg::ST_E6: begin
        cmd_o.mul_sel = rpi_pkg::M_EX_V;
        cmd_o.acc_op  = rpi_pkg::A_LOAD;
        cmd_o.act     = rpi_pkg::ACT_SR;
        state_d       = rpi_pkg::ST_E7;
      end
      rpi_pkg::ST_E7: begin
        cmd_o.mul_sel = rpi_pkg::M_FY_U;
        cmd_o.acc_op  = rpi_pkg::A_SUB;
        state_d       = rpi_pkg::ST_E8;
      end
      rpi_pkg::ST_E8: begin
        cmd_o.mul_sel = rpi_pkg::M_FX_V;
        cmd_o.acc_op  = rpi_pkg::A_LOAD;
        cmd_o.act     = rpi_pkg::ACT_S0;
        state_d       = rpi_pkg::ST_E9;
      end
      rpi_pkg::ST_E9: begin
        cmd_o.acc_op = rpi_pkg::A_SUB;
        state_d      = rpi_pkg::ST_E10;
      end
      rpi_pkg::ST_E10: begin
        cmd_o.act = rpi_pkg::ACT_CROSS;
        state_d   = last_q ? rpi_pkg::ST_DONE : rpi_pkg::ST_NEXT;
      end
      rpi_pkg::ST_NEXT: begin
        cmd_o.act = rpi_pkg::ACT_PREV;
        idx_d     = CW'(idx_q + 1'b1);
        state_d   = rpi_pkg::ST_LOOP;
      end
      rpi_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.act   = rpi_pkg::ACT_OUT;
          out_valid_d = 1'b1;
          state_d     = rpi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rpi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/rpi_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rpi_datapath #(
  parameter int MaxVertices = rpi_pkg::MAX_VERTICES,
  localparam int AW = $clog2(MaxVertices),
  localparam int CW = $clog2(MaxVertices + 1)
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire rpi_pkg::cmd_t                           cmd_i,
  input  wire logic [AW-1:0]                           rd_addr_i,
  output rpi_pkg::status_t                             status_o,
  output logic [CW-1:0]                                vcnt_o,
  input  wire logic                                    cfg_we_i,
  input  wire logic [rpi_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  wire logic [rpi_pkg::OFS_W-1:0]               cfg_data_i,
  input  wire logic [rpi_pkg::IDX_W-1:0]               vertex_index_i,
  input  wire logic signed [rpi_pkg::CRD_W-1:0]        pos_x_i,
  input  wire logic signed [rpi_pkg::CRD_W-1:0]        pos_y_i,
  input  wire logic signed [rpi_pkg::CRD_W-1:0]        pos_z_i,
  input  wire logic signed [rpi_pkg::CRD_W-1:0]        dir_x_i,
  input  wire logic signed [rpi_pkg::CRD_W-1:0]        dir_y_i,
  input  wire logic signed [rpi_pkg::CRD_W-1:0]        dir_z_i,
  output logic                                         hit_o,
  output logic signed [rpi_pkg::CRD_W-1:0]             point_x_o,
  output logic signed [rpi_pkg::CRD_W-1:0]             point_y_o,
  output logic signed [rpi_pkg::CRD_W-1:0]             point_z_o
);

  localparam int CrdW = rpi_pkg::CRD_W;
  localparam int OpW  = rpi_pkg::OP_W;
  localparam int AccW = rpi_pkg::ACC_W;
  localparam int QW   = rpi_pkg::Q_W;
  localparam int DvdW = rpi_pkg::DVD_W;
  localparam int PsW  = rpi_pkg::PSUM_W;

  // configuration
  logic signed [rpi_pkg::PLN_W-1:0] pa_q, pb_q, pc_q;
  logic signed [rpi_pkg::OFS_W-1:0] pd_q;
  logic [rpi_pkg::CNT_W-1:0]        vcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q     <= '0;
      pb_q     <= '0;
      pc_q     <= '0;
      pd_q     <= '0;
      vcount_q <= '0;
    end else if (cfg_we_i) begin
      case (rpi_pkg::cfg_reg_e'(cfg_idx_i))
        rpi_pkg::REG_PLANE_A:      pa_q     <= cfg_data_i[rpi_pkg::PLN_W-1:0];
        rpi_pkg::REG_PLANE_B:      pb_q     <= cfg_data_i[rpi_pkg::PLN_W-1:0];
        rpi_pkg::REG_PLANE_C:      pc_q     <= cfg_data_i[rpi_pkg::PLN_W-1:0];
        rpi_pkg::REG_PLANE_D:      pd_q     <= cfg_data_i;
        rpi_pkg::REG_VERTEX_COUNT: vcount_q <= cfg_data_i[rpi_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign vcnt_o = (int'(vcount_q) > MaxVertices) ? CW'(MaxVertices) : CW'(vcount_q);

  // vertex store, {z, y, x}
  logic [3*CrdW-1:0] vmem_q [MaxVertices];
  logic [3*CrdW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.act == rpi_pkg::ACT_VWRITE && int'(vertex_index_i) < MaxVertices) begin
      vmem_q[AW'(vertex_index_i)] <= {pos_z_i, pos_y_i, pos_x_i};
    end
    rd_q <= vmem_q[rd_addr_i];
  end

  // ray and working registers
  logic signed [CrdW-1:0] o_q [3];
  logic signed [CrdW-1:0] d_q [3];
  logic signed [CrdW-1:0] p_q [3];
  logic signed [2*OpW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [QW-1:0] den_q, num_q;
  logic [QW-1:0] dvs_q;
  logic [QW:0] rem_q;
  logic [DvdW-1:0] dvd_q;
  logic qneg_q, tsmall_q;
  logic [CrdW-2:0] t_q;
  logic signed [CrdW-1:0] first_u_q, first_v_q, prev_u_q, prev_v_q, cur_u_q, cur_v_q;
  logic lsc_ok_q, sl_pos_q, sr_neg_q, sr_pos_q, s0_neg_q, s0_pos_q, par_q;
  logic hit_q;
  logic signed [CrdW-1:0] pt_q [3];

  // dominant axis of the normal
  logic [rpi_pkg::PLN_W-1:0] amag, bmag, cmag;
  logic drop_x, drop_y;
  assign amag   = pa_q[rpi_pkg::PLN_W-1] ? rpi_pkg::PLN_W'(-pa_q) : rpi_pkg::PLN_W'(pa_q);
  assign bmag   = pb_q[rpi_pkg::PLN_W-1] ? rpi_pkg::PLN_W'(-pb_q) : rpi_pkg::PLN_W'(pb_q);
  assign cmag   = pc_q[rpi_pkg::PLN_W-1] ? rpi_pkg::PLN_W'(-pc_q) : rpi_pkg::PLN_W'(pc_q);
  assign drop_x = (amag >= bmag) && (amag >= cmag);
  assign drop_y = !drop_x && (bmag >= cmag);

  logic signed [CrdW-1:0] rd_x, rd_y, rd_z, rd_u, rd_v, pu, pv;
  assign rd_x = rd_q[CrdW-1:0];
  assign rd_y = rd_q[2*CrdW-1:CrdW];
  assign rd_z = rd_q[3*CrdW-1:2*CrdW];
  assign rd_u = drop_x ? rd_y : rd_x;
  assign rd_v = (drop_x || drop_y) ? rd_z : rd_y;
  assign pu   = drop_x ? p_q[1] : p_q[0];
  assign pv   = (drop_x || drop_y) ? p_q[2] : p_q[1];

  // edge terms
  logic signed [OpW-1:0] dx, dy, ex, ey, fx, fy;
  logic [OpW-1:0] dx_mag, dy_mag;
  logic [OpW+2:0] dx7;
  logic vert, horiz;
  assign dx     = OpW'(cur_u_q) - OpW'(prev_u_q);
  assign dy     = OpW'(cur_v_q) - OpW'(prev_v_q);
  assign ex     = OpW'(prev_u_q) - OpW'(pu);
  assign ey     = OpW'(prev_v_q) - OpW'(pv);
  assign fx     = OpW'(cur_u_q) - OpW'(pu);
  assign fy     = OpW'(cur_v_q) - OpW'(pv);
  assign dx_mag = dx[OpW-1] ? OpW'(-dx) : OpW'(dx);
  assign dy_mag = dy[OpW-1] ? OpW'(-dy) : OpW'(dy);
  assign dx7    = {dx_mag, 3'b000} - (OpW + 3)'(dx_mag);
  assign vert   = dx_mag < OpW'(rpi_pkg::EPS);
  assign horiz  = dy_mag < OpW'(rpi_pkg::EPS);

  // shared multiplier
  logic signed [OpW-1:0] mul_a, mul_b, t_op, u_op, v_op;
  assign t_op = OpW'({2'b00, t_q});
  assign u_op = OpW'(rpi_pkg::U_DIR);
  assign v_op = OpW'(rpi_pkg::V_DIR);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      rpi_pkg::M_A_DX:  begin mul_a = OpW'(pa_q); mul_b = OpW'(d_q[0]); end
      rpi_pkg::M_B_DY:  begin mul_a = OpW'(pb_q); mul_b = OpW'(d_q[1]); end
      rpi_pkg::M_C_DZ:  begin mul_a = OpW'(pc_q); mul_b = OpW'(d_q[2]); end
      rpi_pkg::M_A_OX:  begin mul_a = OpW'(pa_q); mul_b = OpW'(o_q[0]); end
      rpi_pkg::M_B_OY:  begin mul_a = OpW'(pb_q); mul_b = OpW'(o_q[1]); end
      rpi_pkg::M_C_OZ:  begin mul_a = OpW'(pc_q); mul_b = OpW'(o_q[2]); end
      rpi_pkg::M_DX_T:  begin mul_a = OpW'(d_q[0]); mul_b = t_op; end
      rpi_pkg::M_DY_T:  begin mul_a = OpW'(d_q[1]); mul_b = t_op; end
      rpi_pkg::M_DZ_T:  begin mul_a = OpW'(d_q[2]); mul_b = t_op; end
      rpi_pkg::M_DY_U:  begin mul_a = dy; mul_b = u_op; end
      rpi_pkg::M_DX_V:  begin mul_a = dx; mul_b = v_op; end
      rpi_pkg::M_DY_EX: begin mul_a = dy; mul_b = ex; end
      rpi_pkg::M_DX_EY: begin mul_a = dx; mul_b = ey; end
      rpi_pkg::M_EY_U:  begin mul_a = ey; mul_b = u_op; end
      rpi_pkg::M_EX_V:  begin mul_a = ex; mul_b = v_op; end
      rpi_pkg::M_FY_U:  begin mul_a = fy; mul_b = u_op; end
      rpi_pkg::M_FX_V:  begin mul_a = fx; mul_b = v_op; end
      default: ;
    endcase
  end

  // derived values
  logic signed [AccW-1:0] acc_neg;
  logic [AccW-1:0] acc_mag;
  logic [QW-1:0] den_mag, num_mag;
  logic [QW:0] r2;
  logic ge;
  logic signed [PsW-1:0] psum;
  logic signed [CrdW-1:0] psat, o_sel;
  logic gate, s1_ok, crossed;

  assign acc_neg = -acc_q;
  assign acc_mag = acc_q[AccW-1] ? AccW'(acc_neg) : AccW'(acc_q);
  assign den_mag = den_q[QW-1] ? QW'(-den_q) : QW'(den_q);
  assign num_mag = num_q[QW-1] ? QW'(-num_q) : QW'(num_q);
  assign r2      = {rem_q[QW-1:0], dvd_q[DvdW-1]};
  assign ge      = r2 >= {1'b0, dvs_q};

  always_comb begin
    case (cmd_i.act)
      rpi_pkg::ACT_PY: o_sel = o_q[1];
      rpi_pkg::ACT_PZ: o_sel = o_q[2];
      default:         o_sel = o_q[0];
    endcase
  end

  assign psum = PsW'(o_sel) + PsW'(prod_q >>> 16);
  assign psat = rpi_pkg::sat32(psum);

  always_comb begin
    if (vert) begin
      gate = !ex[OpW-1];
    end else if (horiz) begin
      gate = !ey[OpW-1];
    end else begin
      gate = lsc_ok_q && !((sl_pos_q && sr_neg_q) || (!sl_pos_q && sr_pos_q));
    end
  end

  assign s1_ok   = (acc_q == '0) || (s0_neg_q && acc_q > 0) || (s0_pos_q && acc_q < 0);
  assign crossed = !(vert && horiz) && gate && s1_ok;

  assign status_o.den_small = den_mag < QW'(rpi_pkg::EPS);
  assign status_o.t_small   = tsmall_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.acc_op)
      rpi_pkg::A_LOAD:   acc_q <= AccW'(prod_q);
      rpi_pkg::A_ADD:    acc_q <= acc_q + AccW'(prod_q);
      rpi_pkg::A_SUB:    acc_q <= acc_q - AccW'(prod_q);
      rpi_pkg::A_LOAD_D: acc_q <= AccW'(pd_q) <<< 16;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q    <= 1'b0;
      tsmall_q <= 1'b0;
    end else begin
      case (cmd_i.act)
        rpi_pkg::ACT_CAPTURE: par_q    <= 1'b0;
        rpi_pkg::ACT_CROSS:   par_q    <= par_q ^ crossed;
        rpi_pkg::ACT_TFIN:
          tsmall_q <= qneg_q || (dvd_q <= DvdW'(rpi_pkg::EPS));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      rpi_pkg::ACT_CAPTURE: begin
        o_q[0] <= pos_x_i;
        o_q[1] <= pos_y_i;
        o_q[2] <= pos_z_i;
        d_q[0] <= dir_x_i;
        d_q[1] <= dir_y_i;
        d_q[2] <= dir_z_i;
      end
      rpi_pkg::ACT_DEN: den_q <= acc_q[QW+15:16];
      rpi_pkg::ACT_NUM: num_q <= acc_neg[QW+15:16];
      rpi_pkg::ACT_DIV_INIT: begin
        dvd_q  <= {num_mag, 16'h0000};
        dvs_q  <= den_mag;
        rem_q  <= '0;
        qneg_q <= num_q[QW-1] ^ den_q[QW-1];
      end
      rpi_pkg::ACT_DIV_STEP: begin
        rem_q <= ge ? (r2 - {1'b0, dvs_q}) : r2;
        dvd_q <= {dvd_q[DvdW-2:0], ge};
      end
      rpi_pkg::ACT_TFIN: begin
        t_q <= (dvd_q > DvdW'(32'h7FFF_FFFF)) ? '1 : dvd_q[CrdW-2:0];
      end
      rpi_pkg::ACT_PX: p_q[0] <= psat;
      rpi_pkg::ACT_PY: p_q[1] <= psat;
      rpi_pkg::ACT_PZ: p_q[2] <= psat;
      rpi_pkg::ACT_FIRST: begin
        first_u_q <= rd_u;
        first_v_q <= rd_v;
        prev_u_q  <= rd_u;
        prev_v_q  <= rd_v;
      end
      rpi_pkg::ACT_CUR: begin
        cur_u_q <= rd_u;
        cur_v_q <= rd_v;
      end
      rpi_pkg::ACT_WRAP: begin
        cur_u_q <= first_u_q;
        cur_v_q <= first_v_q;
      end
      rpi_pkg::ACT_PREV: begin
        prev_u_q <= cur_u_q;
        prev_v_q <= cur_v_q;
      end
      rpi_pkg::ACT_LSC: begin
        lsc_ok_q <= !(acc_mag < AccW'(dx7));
        sl_pos_q <= acc_q > 0;
      end
      rpi_pkg::ACT_SR: begin
        sr_neg_q <= acc_q < 0;
        sr_pos_q <= acc_q > 0;
      end
      rpi_pkg::ACT_S0: begin
        s0_neg_q <= acc_q < 0;
        s0_pos_q <= acc_q > 0;
      end
      rpi_pkg::ACT_OUT: begin
        hit_q    <= par_q;
        pt_q[0]  <= par_q ? p_q[0] : '0;
        pt_q[1]  <= par_q ? p_q[1] : '0;
        pt_q[2]  <= par_q ? p_q[2] : '0;
      end
      default: ;
    endcase
  end

  assign hit_o     = hit_q;
  assign point_x_o = pt_q[0];
  assign point_y_o = pt_q[1];
  assign point_z_o = pt_q[2];

endmodule
`default_nettype wire

@@ sv/ray_polygon_intersect.sv @@
// vertex write requests are accepted back to back while idle
// a ray ends early when it is parallel to the plane, when t is at or below epsilon, or when
// the clamped vertex count is zero; otherwise every edge of the polygon is tested, using
// a 53-step restoring divider for t and one shared 33x33 multiplier;
// one ray at a time, the input stalls until the result is registered
// reset clears control state and configuration; the vertex store is not cleared
`timescale 1ns / 1ps
`default_nettype none
module ray_polygon_intersect #(
  parameter int MaxVertices = rpi_pkg::MAX_VERTICES
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 cmd_i,
  input  wire logic [rpi_pkg::IDX_W-1:0]            vertex_index_i,
  input  wire logic signed [rpi_pkg::CRD_W-1:0]     pos_x_i,
  input  wire logic signed [rpi_pkg::CRD_W-1:0]     pos_y_i,
  input  wire logic signed [rpi_pkg::CRD_W-1:0]     pos_z_i,
  input  wire logic signed [rpi_pkg::CRD_W-1:0]     dir_x_i,
  input  wire logic signed [rpi_pkg::CRD_W-1:0]     dir_y_i,
  input  wire logic signed [rpi_pkg::CRD_W-1:0]     dir_z_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      hit_o,
  output logic signed [rpi_pkg::CRD_W-1:0]          point_x_o,
  output logic signed [rpi_pkg::CRD_W-1:0]          point_y_o,
  output logic signed [rpi_pkg::CRD_W-1:0]          point_z_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [rpi_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [rpi_pkg::OFS_W-1:0]            cfg_data_i
);

  localparam int AW = $clog2(MaxVertices);
  localparam int CW = $clog2(MaxVertices + 1);

  rpi_pkg::cmd_t    cmd;
  rpi_pkg::status_t status;
  logic [AW-1:0]    rd_addr;
  logic [CW-1:0]    vcnt;

  rpi_ctrl #(.MaxVertices(MaxVertices)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .vcnt_i     (vcnt),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  rpi_datapath #(.MaxVertices(MaxVertices)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .status_o      (status),
    .vcnt_o        (vcnt),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .vertex_index_i(vertex_index_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .dir_x_i       (dir_x_i),
    .dir_y_i       (dir_y_i),
    .dir_z_i       (dir_z_i),
    .hit_o         (hit_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_z_o     (point_z_o)
  );

endmodule
`default_nettype wire

@@ sv/rpi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rpi_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic                             cmd_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic                             hit_o,
  input wire logic signed [rpi_pkg::CRD_W-1:0] point_x_o,
  input wire logic signed [rpi_pkg::CRD_W-1:0] point_y_o,
  input wire logic signed [rpi_pkg::CRD_W-1:0] point_z_o
);

  // a ray request keeps the input side busy
  a_ray_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && cmd_i) |=> in_stall_o)
    else $error("ray request did not hold off the input");

  // a miss reports a zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (point_x_o == 0 && point_y_o == 0 && point_z_o == 0))
    else $error("miss result with nonzero point");

  // a vertex write produces no result
  a_vertex_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !cmd_i && !out_valid_o) |=> !out_valid_o)
    else $error("result appeared after vertex write");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(hit_o) && $stable(point_x_o)))
    else $error("stalled result changed");

endmodule

bind ray_polygon_intersect rpi_checker u_rpi_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .cmd_i      (cmd_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .hit_o      (hit_o),
  .point_x_o  (point_x_o),
  .point_y_o  (point_y_o),
  .point_z_o  (point_z_o)
);
`default_nettype wire
